// ----- design/rmsu_pkg.sv -----
// Shared types and constants for the RMSprop / SGD weight update core.
// Depends on nothing; imported by rmsprop_sgd_weight_update_core.
package rmsu_pkg;

	typedef struct packed {
		logic signed [31:0] weight;
		logic signed [31:0] gradient;
		logic [47:0]        sq_cache;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] new_weight;
		logic [47:0]        new_cache;
		logic               saturated;
	} out_word_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_MODE  = 3'd0,
		REG_LR    = 3'd1,
		REG_DECAY = 3'd2,
		REG_EPS   = 3'd3,
		REG_L2    = 3'd4,
		REG_CLIP  = 3'd5
	} reg_idx_t;

	localparam int CFG_DW = 32;

	localparam logic        RST_MODE  = 1'b1;
	localparam logic [23:0] RST_LR    = 24'd167772;
	localparam logic [23:0] RST_DECAY = 24'd16760439;
	localparam logic [23:0] RST_EPS   = 24'd10995;
	localparam logic [31:0] RST_L2    = 32'd4295;
	localparam logic [30:0] RST_CLIP  = 31'd83886080;

	localparam logic [47:0] CACHE_MAX = 48'hFFFF_FFFF_FFFF;

	// root search and long division geometry
	localparam int SQ_BITS = 32;
	localparam int SQ_PER  = 2;
	localparam int SQ_ST   = SQ_BITS / SQ_PER;
	localparam int DV_BITS = 60;
	localparam int DV_PER  = 2;
	localparam int DV_ST   = DV_BITS / DV_PER;

	// stage numbering
	localparam int ST_IN    = 1;
	localparam int ST_MUL1  = 2;
	localparam int ST_MUL2  = 3;
	localparam int ST_SUM   = 4;
	localparam int ST_SQPRE = 5;
	localparam int ST_SQ0   = 6;
	localparam int ST_DVPRE = ST_SQ0 + SQ_ST;
	localparam int ST_DV0   = ST_DVPRE + 1;
	localparam int ST_OUT   = ST_DV0 + DV_ST;

	typedef struct packed {
		logic signed [31:0] w;
		logic [31:0]        wm;
		logic [31:0]        gm;
		logic [30:0]        gcm;
		logic               g_neg;
		logic [47:0]        c;
		logic [63:0]        sq;
		logic [47:0]        dch;
		logic [47:0]        dcl;
		logic [55:0]        lrg;
		logic [63:0]        regp;
		logic [48:0]        dc;
		logic [56:0]        gsh;
		logic [56:0]        gsl;
		logic [47:0]        newc;
		logic               sat_c;
		logic [32:0]        step;
		logic [32:0]        regt;
		logic [63:0]        x;
		logic [63:0]        r;
		logic [DV_BITS-1:0] dvd;
		logic [31:0]        dvs;
		logic [32:0]        rem;
		logic [DV_BITS-1:0] q;
		out_word_t          ow;
	} pipe_t;

endpackage

// ----- design/rmsprop_sgd_weight_update_core.sv -----
// Top level of the RMSprop / SGD element-wise weight update pipeline.
// Depends on rmsu_pkg (types, register indexes, stage numbering).
//
// Usage
//  - Input channel in_valid/in_ready/in_data carries one word: weight,
//    gradient and squared-gradient cache. Output channel out_valid/
//    out_ready/out_data returns new weight, new cache and a saturate flag.
//  - Config port: cfg_we with cfg_idx/cfg_wdata writes one register per
//    clock. Write only while the pipeline is empty.
//  - Throughput is one word per cycle while out_ready is high. Depth is
//    set by the root search (two result bits per stage, 16 stages) and the
//    long division (two quotient bits per stage, 30 stages), plus input,
//    multiply, sum, root operand, division set-up and output stages.
//  - Each stage holds while its successor is full and stalled; a bubble
//    anywhere lets the input side keep taking words while the output word
//    waits. Nothing is dropped or repeated.
//  - arst_n clears every valid bit and loads register defaults (RMSprop,
//    lr 0.01, decay 0.999, eps 1e-8, L2 1e-6, clip 5.0).
module rmsprop_sgd_weight_update_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rmsu_pkg::in_word_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output rmsu_pkg::out_word_t out_data,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_idx,
	input  logic [31:0]       cfg_wdata
);
	import rmsu_pkg::*;

	localparam int NS = ST_OUT;

	// configuration registers
	logic        mode_q;
	logic [23:0] lr_q;
	logic [23:0] decay_q;
	logic [23:0] eps_q;
	logic [31:0] l2_q;
	logic [30:0] clip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= RST_MODE;
			lr_q    <= RST_LR;
			decay_q <= RST_DECAY;
			eps_q   <= RST_EPS;
			l2_q    <= RST_L2;
			clip_q  <= RST_CLIP;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_MODE:  mode_q  <= cfg_wdata[0];
				REG_LR:    lr_q    <= cfg_wdata[23:0];
				REG_DECAY: decay_q <= cfg_wdata[23:0];
				REG_EPS:   eps_q   <= cfg_wdata[23:0];
				REG_L2:    l2_q    <= cfg_wdata[CFG_DW-1:0];
				REG_CLIP:  clip_q  <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	// pipeline: payload, valid bits, per-stage advance
	pipe_t pipe_s [1:NS];
	pipe_t nx     [1:NS];
	logic  vld_s  [1:NS];
	logic  adv    [1:NS];

	// a stage loads when empty or when its successor moves on
	assign adv[NS] = !vld_s[NS] || out_ready;
	for (genvar i = 1; i < NS; i++) begin : g_adv
		assign adv[i] = !vld_s[i] || adv[i+1];
	end

	assign in_ready  = adv[1];
	assign out_valid = vld_s[NS];
	assign out_data  = pipe_s[NS].ow;

	for (genvar i = 1; i <= NS; i++) begin : g_reg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv[i]) begin
				vld_s[i] <= (i == 1) ? in_valid : vld_s[i == 1 ? 1 : i-1];
			end
		end
		always_ff @(posedge clk) begin
			if (adv[i]) begin
				pipe_s[i] <= nx[i];
			end
		end
	end

	// stage 1: magnitudes and gradient clip
	always_comb begin
		pipe_t t;
		t       = '0;
		t.w     = in_data.weight;
		t.wm    = in_data.weight[31] ? 32'(-in_data.weight) : in_data.weight;
		t.g_neg = in_data.gradient[31];
		t.gm    = in_data.gradient[31] ? 32'(-in_data.gradient) : in_data.gradient;
		t.gcm   = (t.gm > {1'b0, clip_q}) ? clip_q : t.gm[30:0];
		t.c     = in_data.sq_cache;
		nx[ST_IN] = t;
	end

	// stage 2: first products
	always_comb begin
		pipe_t t;
		t      = pipe_s[ST_IN];
		t.sq   = t.gm * t.gm;
		t.dch  = decay_q * t.c[47:24];
		t.dcl  = decay_q * t.c[23:0];
		t.lrg  = lr_q * (mode_q ? {1'b0, t.gcm} : t.gm);
		t.regp = l2_q * t.wm;
		nx[ST_MUL1] = t;
	end

	// stage 3: decayed cache, (1-decay)*g^2 partial products
	always_comb begin
		pipe_t       t;
		logic [24:0] omd;
		t     = pipe_s[ST_MUL1];
		omd   = 25'h100_0000 - {1'b0, decay_q};
		t.dc  = {1'b0, t.dch} + 49'((49'(t.dcl) + 49'h80_0000) >> 24);
		t.gsh = omd * t.sq[63:32];
		t.gsl = omd * t.sq[31:0];
		nx[ST_MUL2] = t;
	end

	// stage 4: cache sum with saturation (cache kept in SGD mode), SGD step and L2 term rounding
	always_comb begin
		pipe_t       t;
		logic [57:0] sum;
		t   = pipe_s[ST_MUL2];
		sum = 58'(t.dc) + 58'(t.gsh) + 58'((58'(t.gsl) + 58'h8000_0000) >> 32);
		if (!mode_q) begin
			t.newc  = t.c;
			t.sat_c = 1'b0;
		end else if (sum > 58'(CACHE_MAX)) begin
			t.newc  = CACHE_MAX;
			t.sat_c = 1'b1;
		end else begin
			t.newc  = sum[47:0];
			t.sat_c = 1'b0;
		end
		t.step = 33'((57'(t.lrg) + 57'h80_0000) >> 24);
		t.regt = 33'((65'(t.regp) + 65'h8000_0000) >> 32);
		nx[ST_SUM] = t;
	end

	// stage 5: root operand
	always_comb begin
		pipe_t       t;
		logic [48:0] se;
		t   = pipe_s[ST_SUM];
		se  = 49'(t.newc) + 49'(eps_q);
		t.x = {1'b0, se, 14'd0};
		t.r = '0;
		nx[ST_SQPRE] = t;
	end

	// root search, SQ_PER result bits per stage
	for (genvar k = 0; k < SQ_ST; k++) begin : g_sq
		always_comb begin
			pipe_t       t;
			logic [63:0] x;
			logic [63:0] r;
			logic [63:0] b;
			t = pipe_s[ST_SQ0 + k - 1];
			x = t.x;
			r = t.r;
			for (int j = 0; j < SQ_PER; j++) begin
				b = 64'd1 << (62 - 2 * (k * SQ_PER + j));
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
			end
			t.x = x;
			t.r = r;
			nx[ST_SQ0 + k] = t;
		end
	end

	// division set-up: floor the root at one LSB, add half divisor
	always_comb begin
		pipe_t       t;
		logic [31:0] root;
		t     = pipe_s[ST_DVPRE - 1];
		root  = (t.r[31:0] == 32'd0) ? 32'd1 : t.r[31:0];
		t.dvs = root;
		t.dvd = DV_BITS'({t.lrg, 3'd0}) + DV_BITS'(root >> 1);
		t.rem = '0;
		t.q   = '0;
		nx[ST_DVPRE] = t;
	end

	// restoring long division, DV_PER quotient bits per stage
	for (genvar k = 0; k < DV_ST; k++) begin : g_dv
		always_comb begin
			pipe_t              t;
			logic [32:0]        rem;
			logic [DV_BITS-1:0] q;
			t   = pipe_s[ST_DV0 + k - 1];
			rem = t.rem;
			q   = t.q;
			for (int j = 0; j < DV_PER; j++) begin
				rem = {rem[31:0], t.dvd[DV_BITS - 1 - (k * DV_PER + j)]};
				if (rem >= {1'b0, t.dvs}) begin
					rem = rem - {1'b0, t.dvs};
					q[DV_BITS - 1 - (k * DV_PER + j)] = 1'b1;
				end
			end
			t.rem = rem;
			t.q   = q;
			nx[ST_DV0 + k] = t;
		end
	end

	// output stage: apply step (and L2 term in RMSprop mode), clamp to int32
	always_comb begin
		pipe_t              t;
		logic signed [65:0] wx;
		logic signed [65:0] dl;
		logic signed [65:0] rg;
		logic signed [65:0] nw;
		t  = pipe_s[NS - 1];
		wx = {{34{t.w[31]}}, t.w};
		if (mode_q) begin
			dl = $signed({6'd0, t.q});
			rg = $signed({33'd0, t.regt});
		end else begin
			dl = $signed({33'd0, t.step});
			rg = '0;
		end
		if (t.g_neg) dl = -dl;
		if (t.w[31]) rg = -rg;
		nw = wx - dl - rg;
		t.ow.new_cache = t.newc;
		if (nw > 66'sh7FFF_FFFF) begin
			t.ow.new_weight = 32'sh7FFF_FFFF;
			t.ow.saturated  = 1'b1;
		end else if (nw < -66'sh8000_0000) begin
			t.ow.new_weight = 32'sh8000_0000;
			t.ow.saturated  = 1'b1;
		end else begin
			t.ow.new_weight = nw[31:0];
			t.ow.saturated  = t.sat_c;
		end
		nx[NS] = t;
	end

	// input only backs up when every stage is full and the output is stalled
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled with a bubble in the pipeline");

	// divider must never see a zero divisor
	a_dvs_nz: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_DVPRE] |-> (pipe_s[ST_DVPRE].dvs != 32'd0))
		else $error("zero divisor entered the divider");

	// in SGD mode only the weight clamp can raise the flag
	a_sgd_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !mode_q && out_data.saturated) |->
		(out_data.new_weight == 32'sh7FFF_FFFF || out_data.new_weight == 32'sh8000_0000))
		else $error("saturate flag without weight clamp in SGD mode");

endmodule
